@@ rtl/quaternion_multiply_normalise_top_assert.svh @@
// Assertion macros used by the top-level RTL.
`ifndef QUATERNION_MULTIPLY_NORMALISE_TOP_ASSERT_SVH
`define QUATERNION_MULTIPLY_NORMALISE_TOP_ASSERT_SVH

// Same-cycle implication.
`define QMN_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("qmn check failed");

// Next-cycle implication.
`define QMN_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("qmn check failed");

`endif

@@ rtl/qmn_pkg.sv @@
package qmn_pkg;

  localparam int CompBits = 16;

  typedef struct packed {
    logic signed [CompBits-1:0] a_w;
    logic signed [CompBits-1:0] a_x;
    logic signed [CompBits-1:0] a_y;
    logic signed [CompBits-1:0] a_z;
    logic signed [CompBits-1:0] b_w;
    logic signed [CompBits-1:0] b_x;
    logic signed [CompBits-1:0] b_y;
    logic signed [CompBits-1:0] b_z;
  } req_t;

  typedef struct packed {
    logic signed [CompBits-1:0] out_w;
    logic signed [CompBits-1:0] out_x;
    logic signed [CompBits-1:0] out_y;
    logic signed [CompBits-1:0] out_z;
    logic                       degenerate;
  } rsp_t;

endpackage

@@ rtl/qmn_sqrt.sv @@
// Pipelined restoring square root, one result bit per stage.
// Returns floor root and the final remainder; side data rides along.
module qmn_sqrt #(
  parameter int SW = 66,
  parameter int SB = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          ce,
  input  logic          in_vld,
  input  logic [SW-1:0] s,
  input  logic [SB-1:0] side_in,
  output logic          out_vld,
  output logic [SW/2-1:0] root,
  output logic [SW/2+2:0] rem,
  output logic [SB-1:0] side_out
);

  localparam int NS = SW / 2;
  localparam int RW = NS + 3;

  logic [NS:0]   v;
  logic [SW-1:0] sr [NS+1];
  logic [NS-1:0] rr [NS+1];
  logic [RW-1:0] rm [NS+1];
  logic [SB-1:0] sd [NS+1];

  assign v[0]  = in_vld;
  assign sr[0] = s;
  assign rr[0] = '0;
  assign rm[0] = '0;
  assign sd[0] = side_in;

  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic [RW-1:0] acc;
    logic [RW-1:0] trial;
    logic          take;
    always_comb begin
      acc   = RW'({rm[j][RW-3:0], sr[j][SW-1 -: 2]});
      trial = RW'({rr[j], 2'b01});
      take  = (acc >= trial);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (ce) begin
        v[j+1] <= v[j];
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        sr[j+1] <= {sr[j][SW-3:0], 2'b00};
        rr[j+1] <= NS'({rr[j], take});
        rm[j+1] <= take ? (acc - trial) : acc;
        sd[j+1] <= sd[j];
      end
    end
  end

  assign out_vld  = v[NS];
  assign root     = rr[NS];
  assign rem      = rm[NS];
  assign side_out = sd[NS];

endmodule

@@ rtl/quaternion_multiply_normalise_top.sv @@
// Normalized Hamilton product of two quaternions, fully pipelined: one request
// is accepted every cycle while the output is not stalled. The pipeline has
// 2*CW+1 square-root stages, CW stages of division and eight stages of multiply,
// Hamilton sum, sign and magnitude, square, sum of squares, rounding, divide
// setup and output, with CW = COMPONENT_BITS clamped to the range 2..16.
// The whole pipeline freezes while rsp_stall holds back a waiting result.
// A zero product gives all-zero components with degenerate set.
module quaternion_multiply_normalise_top #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  qmn_pkg::req_t  req_data,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output qmn_pkg::rsp_t  rsp_data
);

  localparam int CW = (COMPONENT_BITS > 16) ? 16 : ((COMPONENT_BITS < 2) ? 2 : COMPONENT_BITS);
  localparam int F  = CW - 2;
  localparam int PS = 2 * CW + 2;
  localparam int PW = 2 * CW + 1;
  localparam int SW = 2 * PW;
  localparam int SB = 1 + 4 + 4 * PW;
  localparam int QB = F + 2;
  localparam int NW = PW + F + 2;
  localparam int RW = NW + 1;
  localparam int OW = qmn_pkg::CompBits;

  logic ce;
  assign ce        = !rsp_valid || !rsp_stall;
  assign req_stall = !ce;

  // stage A: sixteen partial products
  logic signed [CW-1:0]   av [4];
  logic signed [CW-1:0]   bv [4];
  logic signed [2*CW-1:0] prd [4][4];
  logic                   va;

  assign av[0] = req_data.a_w[CW-1:0];
  assign av[1] = req_data.a_x[CW-1:0];
  assign av[2] = req_data.a_y[CW-1:0];
  assign av[3] = req_data.a_z[CW-1:0];
  assign bv[0] = req_data.b_w[CW-1:0];
  assign bv[1] = req_data.b_x[CW-1:0];
  assign bv[2] = req_data.b_y[CW-1:0];
  assign bv[3] = req_data.b_z[CW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ce) begin
      va <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prd[i][j] <= av[i] * bv[j];
        end
      end
    end
  end

  // stage B: Hamilton sums
  logic signed [PS-1:0] e [4][4];
  logic signed [PS-1:0] pb_next [4];
  logic signed [PS-1:0] pb [4];
  logic                 vb;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        e[i][j] = PS'(prd[i][j]);
      end
    end
    pb_next[0] = e[0][0] - e[1][1] - e[2][2] - e[3][3];
    pb_next[1] = e[0][1] + e[1][0] + e[2][3] - e[3][2];
    pb_next[2] = e[0][2] - e[1][3] + e[2][0] + e[3][1];
    pb_next[3] = e[0][3] + e[1][2] - e[2][1] + e[3][0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (ce) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 4; k++) begin
        pb[k] <= pb_next[k];
      end
    end
  end

  // stage C: sign and magnitude
  logic [3:0]          ngc;
  logic [3:0][PW-1:0]  mgc;
  logic                vc;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (ce) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 4; k++) begin
        ngc[k] <= pb[k][PS-1];
        mgc[k] <= pb[k][PS-1] ? PW'(-pb[k]) : PW'(pb[k]);
      end
    end
  end

  // stage D: squares
  logic [SW-1:0]       sqd [4];
  logic [3:0]          ngd;
  logic [3:0][PW-1:0]  mgd;
  logic                vd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (ce) begin
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 4; k++) begin
        sqd[k] <= mgc[k] * mgc[k];
      end
      ngd <= ngc;
      mgd <= mgc;
    end
  end

  // stage E: sum of squares, bounded by 2^(4*CW) so no carry out
  logic [SW-1:0] se;
  logic [SB-1:0] side_e;
  logic          ve;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (ce) begin
      ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      se     <= sqd[0] + sqd[1] + sqd[2] + sqd[3];
      side_e <= {(mgd == '0), ngd, mgd};
    end
  end

  logic          vs;
  logic [PW-1:0] root;
  logic [PW+2:0] rem;
  logic [SB-1:0] side_s;

  qmn_sqrt #(
    .SW(SW),
    .SB(SB)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_vld   (ve),
    .s        (se),
    .side_in  (side_e),
    .out_vld  (vs),
    .root     (root),
    .rem      (rem),
    .side_out (side_s)
  );

  // stage F: round root to nearest
  logic [PW-1:0] mf;
  logic [SB-1:0] side_f;
  logic          vf;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (ce) begin
      vf <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      mf     <= root + PW'(rem > (PW+3)'(root));
      side_f <= side_s;
    end
  end

  logic [3:0][PW-1:0] mg_f;
  logic [3:0]         ng_f;
  logic               dg_f;
  assign {dg_f, ng_f, mg_f} = side_f;

  // division pipeline: quotient = (2*|P|*2^F + M) / (2*M), one bit per stage
  logic [QB:0]   dv;
  logic [RW-1:0] dr [QB+1][4];
  logic [QB-1:0] dq [QB+1][4];
  logic [PW:0]   dd [QB+1];
  logic [3:0]    dn [QB+1];
  logic [QB:0]   dg;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (ce) begin
      dv[0] <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 4; k++) begin
        dr[0][k] <= RW'({mg_f[k], {F{1'b0}}, 1'b0}) + RW'(mf);
        dq[0][k] <= '0;
      end
      dd[0] <= {mf, 1'b0};
      dn[0] <= ng_f;
      dg[0] <= dg_f;
    end
  end

  for (genvar t = 0; t < QB; t++) begin : g_div
    localparam int SH = QB - 1 - t;
    logic [RW-1:0] dsh;
    assign dsh = RW'(dd[t]) << SH;
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[t+1] <= 1'b0;
      end else if (ce) begin
        dv[t+1] <= dv[t];
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        for (int k = 0; k < 4; k++) begin
          if (dr[t][k] >= dsh) begin
            dr[t+1][k] <= dr[t][k] - dsh;
            dq[t+1][k] <= QB'({dq[t][k], 1'b1});
          end else begin
            dr[t+1][k] <= dr[t][k];
            dq[t+1][k] <= QB'({dq[t][k], 1'b0});
          end
        end
        dd[t+1] <= dd[t];
        dn[t+1] <= dn[t];
        dg[t+1] <= dg[t];
      end
    end
  end

  // output stage: saturate to 1.0, apply sign, mask to component width
  localparam logic [QB-1:0] OneFx = QB'(1) << F;
  logic [QB-1:0] qs [4];
  logic [CW-1:0] qc [4];
  logic [OW-1:0] qo [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      qs[k] = (dq[QB][k] > OneFx) ? OneFx : dq[QB][k];
      qc[k] = dn[QB][k] ? CW'(-qs[k]) : CW'(qs[k]);
      qo[k] = dg[QB] ? '0 : OW'(qc[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ce) begin
      rsp_valid <= dv[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rsp_data.out_w      <= qo[0];
      rsp_data.out_x      <= qo[1];
      rsp_data.out_y      <= qo[2];
      rsp_data.out_z      <= qo[3];
      rsp_data.degenerate <= dg[QB];
    end
  end

`include "quaternion_multiply_normalise_top_assert.svh"

  `QMN_ASSERT_NOW(a_degen_zero, clk, rst, rsp_valid && rsp_data.degenerate, (rsp_data.out_w == '0) && (rsp_data.out_x == '0) && (rsp_data.out_y == '0) && (rsp_data.out_z == '0))
  `QMN_ASSERT_NOW(a_unit_nonzero, clk, rst, rsp_valid && !rsp_data.degenerate, (rsp_data.out_w != '0) || (rsp_data.out_x != '0) || (rsp_data.out_y != '0) || (rsp_data.out_z != '0))
  `QMN_ASSERT_NEXT(a_freeze, clk, rst, rsp_valid && rsp_stall, $stable(va) && $stable(dv))

endmodule
